// ===== hdl/oprb_pkg.sv =====
// oprb_pkg: opcodes, status codes and the per-operation result record
// shared by the packet ring head control and the top level
// no dependencies

package oprb_pkg;

    localparam int unsigned PACKET_W = 64;
    localparam int unsigned FILL_W   = 5;

    typedef enum logic [2:0] {
        OP_PUSH       = 3'd0,
        OP_POP_NEXT   = 3'd1,
        OP_SKIP_NEXT  = 3'd2,
        OP_POP_LATEST = 3'd3,
        OP_CLEAR      = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NEVER_PUSHED = 2'd1,
        ST_EMPTY        = 2'd2
    } t_status;

    // what the head control decided for one operation
    typedef struct packed {
        t_status             status;
        logic                pop_ok;
        logic [FILL_W-1:0]   fill_count;
    } t_op_result;

endpackage

// ===== hdl/overwriting_packet_ring_buffer.sv =====
// overwriting_packet_ring_buffer: top level, packet store ram, head control
// and the read-return / output stages; uses oprb_pkg, oprb_ram, oprb_head_ctrl
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | i_opcode, i_packet_data
//   out     | output    | o_out_valid / i_out_stall | o_status, o_packet_out, o_fill_count
//
// one operation per cycle while the input is not stalled; a result passes the store's
// registered read in the read-return stage and then the output register
// heads update at the input transfer, so back-to-back push and pop need no bypass
// synchronous active-low reset empties the pipeline and sets both heads to none
// a stalled output holds its result; input stalls only while both stages are full

module overwriting_packet_ring_buffer #(
    parameter int unsigned RING_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_packet_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_packet_out,
    output logic [4:0]  o_fill_count
);

    localparam int unsigned IW = $clog2(RING_DEPTH);

    logic                             fire;
    logic                             out_free;
    logic                             s1_adv;
    logic                             ram_we;
    logic                             ram_re;
    logic [IW-1:0]                    ram_addr;
    logic [oprb_pkg::PACKET_W-1:0]    ram_rdata;
    oprb_pkg::t_op_result             res;

    logic                             r_s1_valid;
    oprb_pkg::t_op_result             r_s1_res;
    logic                             r_out_valid;
    logic [1:0]                       r_out_status;
    logic [oprb_pkg::PACKET_W-1:0]    r_out_packet;
    logic [oprb_pkg::FILL_W-1:0]      r_out_fill;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign fire       = i_in_valid && !o_in_stall;

    oprb_head_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_head_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_opcode   (i_opcode),
        .o_ram_we   (ram_we),
        .o_ram_re   (ram_re),
        .o_ram_addr (ram_addr),
        .o_res      (res)
    );

    oprb_ram #(
        .WIDTH (oprb_pkg::PACKET_W),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_packet_data),
        .o_rdata (ram_rdata)
    );

    // read-return stage: ram data lines up with this stage and holds while it waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= r_s1_res.status;
            r_out_packet <= r_s1_res.pop_ok ? ram_rdata : '0;
            r_out_fill   <= r_s1_res.fill_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_packet_out = r_out_packet;
    assign o_fill_count = r_out_fill;

endmodule

// ===== hdl/oprb_ram.sv =====
// oprb_ram: generic single-port synchronous ram with registered read
// depends on nothing

module oprb_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/oprb_head_ctrl.sv =====
// oprb_head_ctrl: producer and consumer head registers, opcode decode,
// store access request and fill count; uses oprb_pkg

module oprb_head_ctrl #(
    parameter int unsigned RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [2:0]                    i_opcode,
    output logic                          o_ram_we,
    output logic                          o_ram_re,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_addr,
    output oprb_pkg::t_op_result          o_res
);

    localparam int unsigned IW = $clog2(RING_DEPTH);
    localparam int unsigned CW = (IW + 1 > oprb_pkg::FILL_W) ? IW + 1 : oprb_pkg::FILL_W;
    localparam logic [IW-1:0] LAST = IW'(RING_DEPTH - 1);

    // a head is either none or a slot index
    logic          r_p_none, n_p_none;
    logic [IW-1:0] r_p_idx,  n_p_idx;
    logic          r_c_none, n_c_none;
    logic [IW-1:0] r_c_idx,  n_c_idx;

    logic [IW-1:0] p_next, c_next, pop_idx;
    logic          heads_eq, n_heads_eq;
    logic          we, re;
    logic [IW-1:0] addr;
    oprb_pkg::t_status status;
    logic          pop_ok;
    logic [CW-1:0] fill;

    assign p_next = (r_p_none || r_p_idx == LAST) ? '0 : r_p_idx + 1'b1;
    assign c_next = (r_c_none || r_c_idx == LAST) ? '0 : r_c_idx + 1'b1;

    assign heads_eq = (r_p_none && r_c_none)
                   || (!r_p_none && !r_c_none && r_p_idx == r_c_idx);

    always_comb begin
        n_p_none = r_p_none;
        n_p_idx  = r_p_idx;
        n_c_none = r_c_none;
        n_c_idx  = r_c_idx;
        we       = 1'b0;
        re       = 1'b0;
        addr     = p_next;
        status   = oprb_pkg::ST_OK;
        pop_ok   = 1'b0;
        pop_idx  = (i_opcode == oprb_pkg::OP_POP_NEXT) ? c_next : r_p_idx;
        case (i_opcode)
            oprb_pkg::OP_PUSH: begin
                n_p_none = 1'b0;
                n_p_idx  = p_next;
                we       = 1'b1;
                addr     = p_next;
            end
            oprb_pkg::OP_POP_NEXT, oprb_pkg::OP_POP_LATEST: begin
                if (r_p_none) begin
                    status = oprb_pkg::ST_NEVER_PUSHED;
                end else if (heads_eq) begin
                    status = oprb_pkg::ST_EMPTY;
                end else begin
                    pop_ok   = 1'b1;
                    re       = 1'b1;
                    addr     = pop_idx;
                    n_c_none = 1'b0;
                    n_c_idx  = pop_idx;
                end
            end
            oprb_pkg::OP_SKIP_NEXT: begin
                n_c_none = 1'b0;
                n_c_idx  = c_next;
            end
            oprb_pkg::OP_CLEAR: begin
                n_p_none = 1'b1;
                n_p_idx  = '0;
                n_c_none = 1'b1;
                n_c_idx  = '0;
            end
            default: begin
            end
        endcase
    end

    // fill count after the operation, consumer none counts as minus one
    assign n_heads_eq = (n_p_none && n_c_none)
                     || (!n_p_none && !n_c_none && n_p_idx == n_c_idx);

    always_comb begin
        if (n_p_none || n_heads_eq) begin
            fill = '0;
        end else if (n_c_none) begin
            fill = CW'(n_p_idx) + CW'(1);
        end else if (n_p_idx > n_c_idx) begin
            fill = CW'(n_p_idx) - CW'(n_c_idx);
        end else begin
            fill = CW'(RING_DEPTH) - CW'(n_c_idx) + CW'(n_p_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_none <= 1'b1;
            r_p_idx  <= '0;
            r_c_none <= 1'b1;
            r_c_idx  <= '0;
        end else if (i_fire) begin
            r_p_none <= n_p_none;
            r_p_idx  <= n_p_idx;
            r_c_none <= n_c_none;
            r_c_idx  <= n_c_idx;
        end
    end

    assign o_ram_we         = i_fire && we;
    assign o_ram_re         = i_fire && re;
    assign o_ram_addr       = addr;
    assign o_res.status     = status;
    assign o_res.pop_ok     = pop_ok;
    assign o_res.fill_count = fill[oprb_pkg::FILL_W-1:0];

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for overwriting_packet_ring_buffer, mirrors the ring heads and
// packet slots to predict every result; depends on oprb_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH       = 16;
    localparam int HEAD_NONE   = -1;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;
    localparam int TAIL_CYCLES = 8;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] packet;
        logic [4:0]  fill;
    } t_reply;

    // keeps its own heads and slots, queues the reply each operation should produce
    class ring_mirror;
        int          prod_head;
        int          cons_head;
        logic [63:0] slots [DEPTH];
        bit          filled [DEPTH];
        t_reply      replies_due [$];
        int          errors;

        function new();
            prod_head = HEAD_NONE;
            cons_head = HEAD_NONE;
            errors    = 0;
            foreach (slots[i]) begin
                slots[i]  = '0;
                filled[i] = 1'b0;
            end
        endfunction

        function int advance(int h);
            return (h < 0 || h >= DEPTH - 1) ? 0 : h + 1;
        endfunction

        function logic [4:0] unread();
            int n;
            if (prod_head == cons_head || prod_head < 0)
                n = 0;
            else if (prod_head > cons_head)
                n = prod_head - cons_head;
            else
                n = DEPTH - cons_head + prod_head;
            return n[4:0];
        endfunction

        // a pop-next that would land on a slot never written since reset
        function bit reads_blank(logic [2:0] op);
            return op == oprb_pkg::OP_POP_NEXT && prod_head >= 0 && cons_head != prod_head
                && !filled[advance(cons_head)];
        endfunction

        function void apply_op(logic [2:0] op, logic [63:0] data);
            t_reply r;
            int     idx;
            r.status = oprb_pkg::ST_OK;
            r.packet = '0;
            case (op)
                oprb_pkg::OP_PUSH: begin
                    prod_head         = advance(prod_head);
                    slots[prod_head]  = data;
                    filled[prod_head] = 1'b1;
                end
                oprb_pkg::OP_POP_NEXT, oprb_pkg::OP_POP_LATEST: begin
                    if (prod_head < 0) begin
                        r.status = oprb_pkg::ST_NEVER_PUSHED;
                    end else if (cons_head == prod_head) begin
                        r.status = oprb_pkg::ST_EMPTY;
                    end else begin
                        idx       = (op == oprb_pkg::OP_POP_NEXT) ? advance(cons_head)
                                                                  : prod_head;
                        r.packet  = slots[idx];
                        cons_head = idx;
                    end
                end
                oprb_pkg::OP_SKIP_NEXT: cons_head = advance(cons_head);
                oprb_pkg::OP_CLEAR: begin
                    prod_head = HEAD_NONE;
                    cons_head = HEAD_NONE;
                end
                default: ;
            endcase
            r.fill = unread();
            replies_due.push_back(r);
        endfunction

        function void match_reply(logic [1:0] status, logic [63:0] packet, logic [4:0] fill);
            t_reply want;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d packet %h fill %0d",
                         $time, status, packet, fill);
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            end
            if (packet !== want.packet) begin
                errors++;
                $display("%0t: packet_out expected %h actual %h", $time, want.packet, packet);
            end
            if (fill !== want.fill) begin
                errors++;
                $display("%0t: fill_count expected %0d actual %0d", $time, want.fill, fill);
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [2:0]  i_opcode      = '0;
    logic [63:0] i_packet_data = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [63:0] o_packet_out;
    logic [4:0]  o_fill_count;

    ring_mirror mirror = new();
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int quiet_cycles;

    overwriting_packet_ring_buffer #(
        .RING_DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_packet_data (i_packet_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_packet_out  (o_packet_out),
        .o_fill_count  (o_fill_count)
    );

    always #5 i_clk = ~i_clk;

    // result side: check each transfer, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.match_reply(o_status, o_packet_out, o_fill_count);
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // returns right after the edge that took the transfer, valid still high
    task automatic send_op(input logic [2:0] op, input logic [63:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_packet_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        mirror.apply_op(op, data);
    endtask

    task automatic run_directed();
        send_op(oprb_pkg::OP_POP_NEXT, rand_word());      // never pushed
        send_op(oprb_pkg::OP_POP_LATEST, rand_word());
        send_op(OP_SPARE_MID, rand_word());
        send_op(oprb_pkg::OP_SKIP_NEXT, rand_word());     // consumer moves with no producer
        send_op(oprb_pkg::OP_CLEAR, rand_word());
        send_op(oprb_pkg::OP_PUSH, 64'h0);
        send_op(oprb_pkg::OP_PUSH, '1);
        send_op(oprb_pkg::OP_POP_NEXT, rand_word());
        send_op(oprb_pkg::OP_POP_NEXT, rand_word());
        send_op(oprb_pkg::OP_POP_NEXT, rand_word());      // heads equal
        send_op(oprb_pkg::OP_POP_LATEST, rand_word());
        send_op(oprb_pkg::OP_PUSH, 64'h5555_5555_5555_5555);
        send_op(oprb_pkg::OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(oprb_pkg::OP_POP_LATEST, rand_word());
        send_op(oprb_pkg::OP_SKIP_NEXT, rand_word());     // consumer passes the producer
        send_op(OP_SPARE_FIRST, rand_word());
        send_op(OP_SPARE_LAST, rand_word());
        send_op(oprb_pkg::OP_CLEAR, rand_word());
        send_op(oprb_pkg::OP_POP_NEXT, rand_word());
        send_op(oprb_pkg::OP_PUSH, rand_word());
        send_op(oprb_pkg::OP_POP_NEXT, rand_word());
    endtask

    task automatic run_random(input int items);
        int          done;
        int          n;
        int          roll;
        logic [2:0]  op;
        done = 0;
        while (done < items) begin
            if ($urandom_range(9) == 0) begin
                // push burst of 12 to 24, long enough at its upper end to wrap and overwrite
                n = $urandom_range(24, 12);
                repeat (n) send_op(oprb_pkg::OP_PUSH, rand_word());
                done += n;
            end else begin
                roll = $urandom_range(99);
                if (roll < 40)      op = oprb_pkg::OP_PUSH;
                else if (roll < 65) op = oprb_pkg::OP_POP_NEXT;
                else if (roll < 75) op = oprb_pkg::OP_POP_LATEST;
                else if (roll < 85) op = oprb_pkg::OP_SKIP_NEXT;
                else if (roll < 91) op = oprb_pkg::OP_CLEAR;
                else                op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
                if (mirror.reads_blank(op))
                    op = oprb_pkg::OP_POP_LATEST;
                send_op(op, rand_word());
                done++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1:       begin sender_idle_pct = 85; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 85; end
                3:       begin sender_idle_pct = 28; stall_pct = 28; end
                default: begin sender_idle_pct = 0;  stall_pct = 0;  end
            endcase
            run_random(PHASE_ITEMS);
        end
        i_in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== overwriting_packet_ring_buffer.f =====
hdl/oprb_pkg.sv
hdl/oprb_ram.sv
hdl/oprb_head_ctrl.sv
hdl/overwriting_packet_ring_buffer.sv
sim/tb.sv
